// ===== hdl/orl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types, codes and sizes for the ordered record list.
// ----------------------------------------------------------------------------
package orl_pkg;

  localparam int DEPTH     = 128;
  localparam int STR_BYTES = 8;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = 8;
  localparam int TXT_W     = 64;

  // locate tree: priority groups, then OR-reduction partitions
  localparam int GRP   = 8;
  localparam int NGRP  = DEPTH / GRP;
  localparam int PG    = 16;
  localparam int NPART = DEPTH / PG;

  localparam logic [TXT_W-1:0] TEXT_MASK = {TXT_W{1'b1}} >> (TXT_W - 8 * STR_BYTES);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        position;
    logic [TXT_W-1:0]  rec_date;
    logic [TXT_W-1:0]  rec_time;
    logic [TXT_W-1:0]  rec_place;
    logic signed [15:0] rec_temp;
    logic [15:0]       rec_hum;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         found_pos;
    logic [TXT_W-1:0]   out_date;
    logic [TXT_W-1:0]   out_time;
    logic [TXT_W-1:0]   out_place;
    logic signed [15:0] out_temp;
    logic [15:0]        out_hum;
    logic [CNT_W-1:0]   count;
  } out_item_t;

  typedef struct packed {
    logic [TXT_W-1:0]   r_date;
    logic [TXT_W-1:0]   r_time;
    logic [TXT_W-1:0]   r_place;
    logic signed [15:0] r_temp;
    logic [15:0]        r_hum;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_LOAD,
    CM_FROM_LO,
    CM_FROM_HI
  } cell_mode_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [CNT_W-1:0] pos;
    rec_t             rec;
  } find_res_t;

endpackage

// ===== hdl/orl_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_cell
// One list slot: holds a record, loads from either neighbor or the new item,
// and compares its keys against the locate keys.
// ----------------------------------------------------------------------------
module orl_cell
  import orl_pkg::*;
(
  input  logic             clk,
  input  cell_mode_t       mode,
  input  rec_t             new_rec,
  input  rec_t             lo_rec,
  input  rec_t             hi_rec,
  input  logic [TXT_W-1:0] key_time,
  input  logic [TXT_W-1:0] key_place,
  output rec_t             rec,
  output logic             match
);

  rec_t rec_r;
  rec_t rec_nxt;

  always_comb begin
    case (mode)
      CM_HOLD:    rec_nxt = rec_r;
      CM_LOAD:    rec_nxt = new_rec;
      CM_FROM_LO: rec_nxt = lo_rec;
      CM_FROM_HI: rec_nxt = hi_rec;
      default:    rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec   = rec_r;
  assign match = (rec_r.r_time == key_time) && (rec_r.r_place == key_place);

endmodule

// ===== hdl/orl_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_find
// Locate tree: registers the hit vector, picks the first hit by group
// priority, then OR-reduces the selected record and index in two steps.
// ----------------------------------------------------------------------------
module orl_find
  import orl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DEPTH-1:0] hit,
  input  rec_t             recs [DEPTH],
  output find_res_t        res
);

  logic [DEPTH-1:0] hit_r;
  logic             va_r;

  logic [NGRP-1:0]  grp_any;
  logic [NGRP-1:0]  gsel;
  logic             seen_g;
  logic             seen_l;
  logic [DEPTH-1:0] sel_nxt;
  logic [DEPTH-1:0] sel_r;
  logic             vb_r;
  logic             found_b_r;

  logic [REC_W-1:0] part_rec_nxt [NPART];
  logic [IDX_W-1:0] part_idx_nxt [NPART];
  logic [REC_W-1:0] part_rec_r   [NPART];
  logic [IDX_W-1:0] part_idx_r   [NPART];
  logic             vc_r;
  logic             found_c_r;

  logic [REC_W-1:0] rec_or;
  logic [IDX_W-1:0] idx_or;

  // first hit: priority inside each group, then among groups
  always_comb begin
    seen_g  = 1'b0;
    sel_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |hit_r[g*GRP +: GRP];
      gsel[g]    = grp_any[g] & ~seen_g;
      seen_g     = seen_g | grp_any[g];
    end
    for (int g = 0; g < NGRP; g++) begin
      seen_l = 1'b0;
      for (int j = 0; j < GRP; j++) begin
        sel_nxt[g*GRP+j] = hit_r[g*GRP+j] & ~seen_l & gsel[g];
        seen_l           = seen_l | hit_r[g*GRP+j];
      end
    end
  end

  always_comb begin
    for (int p = 0; p < NPART; p++) begin
      part_rec_nxt[p] = '0;
      part_idx_nxt[p] = '0;
      for (int j = 0; j < PG; j++) begin
        if (sel_r[p*PG+j]) begin
          part_rec_nxt[p] = part_rec_nxt[p] | recs[p*PG+j];
          part_idx_nxt[p] = part_idx_nxt[p] | IDX_W'(p*PG+j);
        end
      end
    end
  end

  always_comb begin
    rec_or = '0;
    idx_or = '0;
    for (int p = 0; p < NPART; p++) begin
      rec_or = rec_or | part_rec_r[p];
      idx_or = idx_or | part_idx_r[p];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= go;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
    hit_r      <= hit;
    sel_r      <= sel_nxt;
    found_b_r  <= |hit_r;
    found_c_r  <= found_b_r;
    part_rec_r <= part_rec_nxt;
    part_idx_r <= part_idx_nxt;
  end

  assign res.busy  = va_r | vb_r | vc_r;
  assign res.done  = vc_r;
  assign res.found = found_c_r;
  assign res.pos   = CNT_W'(idx_or) + CNT_W'(1);
  assign res.rec   = rec_t'(rec_or);

endmodule

// ===== hdl/ordered_record_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_record_list_top
// Ordered table of sensor records with insert, delete and locate.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. It carries
//   an opcode (insert, delete, locate), a 1-based position and a record.
//   Every item gives exactly one result on out_item, flagged by out_strobe
//   for a single cycle; the receiver must take it then.
//   Insert and delete shift the whole row of cells at once: the result
//   appears in the cycle after the item, and busy stays low, so these items
//   can follow each other every cycle.
//   Locate compares all cells at once, then runs a three-stage first-hit and
//   OR-reduction tree (hit vector, first-hit select, partition OR); the result
//   is registered behind it, and busy is high while the item is in the tree.
//   Reset clears the record count and the result strobe; record contents
//   are not cleared and are only ever read below the count.
// ----------------------------------------------------------------------------
module ordered_record_list_top
  import orl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_strobe_r;
  logic             out_strobe_nxt;
  out_item_t        out_r;
  out_item_t        out_nxt;

  logic             acc;
  logic             ins_go;
  logic             del_go;
  logic [1:0]       op_status;
  logic [IDX_W-1:0] k;
  rec_t             new_rec;
  logic [TXT_W-1:0] key_time;
  logic [TXT_W-1:0] key_place;

  cell_mode_t       mode  [DEPTH];
  rec_t             cell_rec [DEPTH];
  logic [DEPTH-1:0] cell_match;
  logic [DEPTH-1:0] hit;
  find_res_t        fres;

  assign acc       = start & ~fres.busy;
  assign busy      = fres.busy;
  assign key_time  = in_item.rec_time & TEXT_MASK;
  assign key_place = in_item.rec_place & TEXT_MASK;
  assign k         = IDX_W'(in_item.position - 8'd1);

  assign new_rec.r_date  = in_item.rec_date & TEXT_MASK;
  assign new_rec.r_time  = key_time;
  assign new_rec.r_place = key_place;
  assign new_rec.r_temp  = in_item.rec_temp;
  assign new_rec.r_hum   = in_item.rec_hum;

  always_comb begin
    ins_go    = 1'b0;
    del_go    = 1'b0;
    op_status = ST_OK;
    count_nxt = count_r;
    case (in_item.opcode)
      OP_INSERT: begin
        if (in_item.position == 8'd0 ||
            {1'b0, in_item.position} > ({1'b0, count_r} + 9'd1)) begin
          op_status = ST_BAD_POS;
        end else if (count_r >= CNT_W'(DEPTH)) begin
          op_status = ST_FULL;
        end else begin
          ins_go = acc;
        end
      end
      OP_DELETE: begin
        if (in_item.position == 8'd0 || in_item.position > count_r) begin
          op_status = ST_BAD_POS;
        end else begin
          del_go = acc;
        end
      end
      OP_LOCATE: op_status = ST_NOT_FOUND;
      default:   op_status = ST_BAD_POS;
    endcase
    if (ins_go) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_go) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_comb begin
      mode[i] = CM_HOLD;
      if (ins_go) begin
        if (IDX_W'(i) > k) begin
          mode[i] = CM_FROM_LO;
        end else if (IDX_W'(i) == k) begin
          mode[i] = CM_LOAD;
        end
      end else if (del_go && IDX_W'(i) >= k) begin
        mode[i] = CM_FROM_HI;
      end
    end

    assign hit[i] = cell_match[i] && (CNT_W'(i) < count_r) && acc &&
                    (in_item.opcode == OP_LOCATE);

    orl_cell u_cell (
      .clk       (clk),
      .mode      (mode[i]),
      .new_rec   (new_rec),
      .lo_rec    ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i - 1]),
      .hi_rec    ((i == DEPTH - 1) ? new_rec
                                   : cell_rec[(i == DEPTH - 1) ? i : i + 1]),
      .key_time  (key_time),
      .key_place (key_place),
      .rec       (cell_rec[i]),
      .match     (cell_match[i])
    );
  end

  orl_find u_find (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (acc && (in_item.opcode == OP_LOCATE)),
    .hit   (hit),
    .recs  (cell_rec),
    .res   (fres)
  );

  always_comb begin
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    if (acc && in_item.opcode != OP_LOCATE) begin
      out_nxt        = '0;
      out_nxt.status = op_status;
      out_nxt.count  = count_nxt;
      out_strobe_nxt = 1'b1;
    end else if (fres.done) begin
      out_nxt        = '0;
      out_nxt.count  = count_r;
      out_strobe_nxt = 1'b1;
      if (fres.found) begin
        out_nxt.status    = ST_OK;
        out_nxt.found_pos = fres.pos;
        out_nxt.out_date  = fres.rec.r_date;
        out_nxt.out_time  = fres.rec.r_time;
        out_nxt.out_place = fres.rec.r_place;
        out_nxt.out_temp  = fres.rec.r_temp;
        out_nxt.out_hum   = fres.rec.r_hum;
      end else begin
        out_nxt.status = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ===== hdl/orl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orl_checker
// Port-level checks on result timing and result contents; bound to the top.
// ----------------------------------------------------------------------------
module orl_checker
  import orl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  a_short_op_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode != OP_LOCATE |=> out_strobe)
    else $error("insert/delete item gave no result in the next cycle");

  a_locate_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == OP_LOCATE |-> ##4 out_strobe)
    else $error("locate item gave no result after four cycles");

  a_locate_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_item.opcode == OP_LOCATE |=> busy && !out_strobe)
    else $error("locate item did not hold off the input");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.found_pos != 8'd0 |->
      out_item.found_pos <= out_item.count && out_item.status == ST_OK)
    else $error("found position outside the held records");

endmodule

bind ordered_record_list_top orl_checker u_orl_checker (.*);

// ===== tb/ordered_record_list_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_record_list_top_tb
// Self-checking testbench for the ordered sensor record list.
// ----------------------------------------------------------------------------
// A directed sequence covers empty-table cases, bad positions, inserts at the
// front, middle and end, duplicate locate keys, the unused opcode and field
// extremes. Random traffic then grows the table to full, shrinks it and mixes
// operations, under three sender idle profiles. Every accepted item is
// applied to a mirror of the table, and each result is checked field by
// field against the oldest expected reply.
// ----------------------------------------------------------------------------
module ordered_record_list_top_tb;
  import orl_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         TAIL_CYCLES = 8;

  localparam int MOOD_GROW   = 0;
  localparam int MOOD_SHRINK = 1;
  localparam int MOOD_MIX    = 2;

  class list_mirror;
    rec_t        rows[DEPTH];
    int unsigned n_rows;
    out_item_t   replies_due[$];
    int unsigned n_errors;

    function new();
      n_rows   = 0;
      n_errors = 0;
    endfunction

    function void apply_request(in_item_t req);
      out_item_t   r;
      rec_t        nr;
      int unsigned p;
      r              = '0;
      p              = 32'(req.position);
      nr.r_date      = req.rec_date & TEXT_MASK;
      nr.r_time      = req.rec_time & TEXT_MASK;
      nr.r_place     = req.rec_place & TEXT_MASK;
      nr.r_temp      = req.rec_temp;
      nr.r_hum       = req.rec_hum;
      r.status       = ST_OK;
      case (req.opcode)
        OP_INSERT: begin
          if (p < 1 || p > n_rows + 1) begin
            r.status = ST_BAD_POS;
          end else if (n_rows >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (int j = n_rows; j >= int'(p); j--) rows[j] = rows[j-1];
            rows[p-1] = nr;
            n_rows++;
          end
        end
        OP_DELETE: begin
          if (p < 1 || p > n_rows) begin
            r.status = ST_BAD_POS;
          end else begin
            for (int j = p; j < int'(n_rows); j++) rows[j-1] = rows[j];
            n_rows--;
          end
        end
        OP_LOCATE: begin
          r.status = ST_NOT_FOUND;
          for (int j = 0; j < int'(n_rows); j++) begin
            if (r.status == ST_NOT_FOUND && rows[j].r_time == nr.r_time &&
                rows[j].r_place == nr.r_place) begin
              r.status    = ST_OK;
              r.found_pos = 8'(j + 1);
              r.out_date  = rows[j].r_date;
              r.out_time  = rows[j].r_time;
              r.out_place = rows[j].r_place;
              r.out_temp  = rows[j].r_temp;
              r.out_hum   = rows[j].r_hum;
            end
          end
        end
        default: r.status = ST_BAD_POS;
      endcase
      r.count = 8'(n_rows);
      replies_due.push_back(r);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void compare_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        $error("result with no item outstanding: %0h", got);
        n_errors++;
      end else begin
        want = replies_due.pop_front();
        check_field("status",    64'(want.status),    64'(got.status));
        check_field("found_pos", 64'(want.found_pos), 64'(got.found_pos));
        check_field("out_date",  want.out_date,       got.out_date);
        check_field("out_time",  want.out_time,       got.out_time);
        check_field("out_place", want.out_place,      got.out_place);
        check_field("out_temp",  64'(want.out_temp),  64'(got.out_temp));
        check_field("out_hum",   64'(want.out_hum),   64'(got.out_hum));
        check_field("count",     64'(want.count),     64'(got.count));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_item;

  list_mirror  list_ref;
  int unsigned idle_pct;
  int unsigned cycle_cnt = 0;
  string       text_pool[4] = '{"12:00", "13:30", "LAB", "ROOF"};

  ordered_record_list_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) list_ref.compare_reply(out_item);
      if (start && !busy) list_ref.apply_request(in_item);
    end
  end

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] w;
    w = '0;
    for (int i = 0; i < s.len() && i < 8; i++) w[8*i +: 8] = s[i];
    return w;
  endfunction

  function automatic logic [63:0] rand_text();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll < 6) return pack_text(text_pool[$urandom_range(3)]);
    if (roll < 9) return {$urandom, $urandom};
    return ($urandom_range(1) != 0) ? '1 : '0;
  endfunction

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] pos,
                                         logic [63:0] d, logic [63:0] t,
                                         logic [63:0] pl, logic [15:0] tmp,
                                         logic [15:0] hum);
    in_item_t it;
    it.opcode    = op;
    it.position  = pos;
    it.rec_date  = d;
    it.rec_time  = t;
    it.rec_place = pl;
    it.rec_temp  = tmp;
    it.rec_hum   = hum;
    return it;
  endfunction

  // row count is read as a hint only; it may lag the latest item by one
  function automatic in_item_t random_item(input int mood);
    in_item_t    it;
    int unsigned n, roll, ins_w, del_w, idx;
    n           = list_ref.n_rows;
    it.rec_date  = rand_text();
    it.rec_time  = rand_text();
    it.rec_place = rand_text();
    it.rec_temp  = 16'($urandom);
    it.rec_hum   = 16'($urandom);
    it.position  = 8'($urandom);
    case (mood)
      MOOD_GROW:   begin ins_w = 80; del_w = 5;  end
      MOOD_SHRINK: begin ins_w = 10; del_w = 70; end
      default:     begin ins_w = 40; del_w = 30; end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w) begin
      it.opcode = OP_INSERT;
      if ($urandom_range(9) != 0) it.position = 8'($urandom_range(n + 1, 1));
      else if ($urandom_range(1) != 0) it.position = 8'd0;
      else it.position = 8'($urandom_range(255, n + 2));
    end else if (roll < ins_w + del_w) begin
      it.opcode = OP_DELETE;
      if (n > 0 && $urandom_range(9) != 0) it.position = 8'($urandom_range(n, 1));
      else if ($urandom_range(1) != 0) it.position = 8'd0;
      else it.position = 8'($urandom_range(255, n + 1));
    end else if (roll < 97) begin
      it.opcode = OP_LOCATE;
      if (n > 0 && $urandom_range(9) < 6) begin
        idx         = $urandom_range(n - 1);
        it.rec_time = list_ref.rows[idx].r_time;
        if ($urandom_range(4) != 0) it.rec_place = list_ref.rows[idx].r_place;
      end
    end else begin
      it.opcode = OP_UNUSED;
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [63:0] t_noon, p_lab, p_roof;
    t_noon = pack_text("12:00");
    p_lab  = pack_text("LAB");
    p_roof = pack_text("ROOF");
    send_item(make_item(OP_LOCATE, 8'd1, '0, t_noon, p_lab, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd1, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_INSERT, 8'd0, '1, t_noon, p_lab, 16'd5, 16'd5));
    send_item(make_item(OP_INSERT, 8'd2, '1, t_noon, p_lab, 16'd5, 16'd5));
    send_item(make_item(OP_INSERT, 8'd1, '1, t_noon, p_lab, 16'h8000, 16'h0000));
    send_item(make_item(OP_INSERT, 8'd2, '0, '1, '1, 16'h7fff, 16'hffff));
    send_item(make_item(OP_INSERT, 8'd1, pack_text("2024"), t_noon, p_lab,
                        16'd1, 16'd2));
    send_item(make_item(OP_INSERT, 8'd2, pack_text("Jan01"), pack_text("13:30"),
                        p_roof, 16'hffff, 16'd1234));
    send_item(make_item(OP_INSERT, 8'd255, '1, '1, '1, 16'hffff, 16'hffff));
    send_item(make_item(OP_INSERT, 8'd6, '1, '1, '1, 16'hffff, 16'hffff));
    send_item(make_item(OP_LOCATE, 8'd0, '0, t_noon, p_lab, 16'd0, 16'd0));
    send_item(make_item(OP_LOCATE, 8'd0, '0, '1, '1, 16'd0, 16'd0));
    send_item(make_item(OP_LOCATE, 8'd0, '0, t_noon, p_roof, 16'd0, 16'd0));
    send_item(make_item(OP_LOCATE, 8'd255, '1, '0, '0, 16'hffff, 16'hffff));
    send_item(make_item(OP_UNUSED, 8'd1, '1, t_noon, p_lab, 16'hffff, 16'hffff));
    send_item(make_item(OP_DELETE, 8'd5, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd0, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd1, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_LOCATE, 8'd0, '0, t_noon, p_lab, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd3, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd1, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd1, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_DELETE, 8'd255, '0, '0, '0, 16'd0, 16'd0));
    send_item(make_item(OP_LOCATE, 8'd0, '0, '1, '1, 16'd0, 16'd0));
  endtask

  initial begin
    int unsigned sender_idle[3];
    list_ref       = new();
    sender_idle[0] = 34;
    sender_idle[1] = 75;
    sender_idle[2] = 0;
    idle_pct       = sender_idle[0];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = sender_idle[ph];
      for (int k = 0; k < 200; k++) send_item(random_item(MOOD_GROW));
      for (int k = 0; k < 150; k++) send_item(random_item(MOOD_SHRINK));
      for (int k = 0; k < 100; k++) send_item(random_item(MOOD_MIX));
    end
    start <= 1'b0;
    while (list_ref.replies_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (list_ref.n_errors == 0 && list_ref.replies_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
